// ----- hw/rtl/brbp_pkg.sv -----
// Shared types and constants for the byte ring buffer with peek.
package brbp_pkg;

  // Default geometry, handed to the top level parameters.
  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned RESERVE_DEF   = 1;
  localparam int unsigned MAX_BURST_DEF = 64;

  // Fixed field widths.
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned AMOUNT_W = 11;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned MOVED_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DROP  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  // Result descriptor from the controller; data comes from the store when from_mem is set.
  typedef struct packed {
    logic               valid;
    logic               from_mem;
    logic               last;
    logic               ok;
    logic [MOVED_W-1:0] moved;
  } res_t;

endpackage

// ----- hw/rtl/brbp_ram.sv -----
// Byte store: one write port, one read port, registered read data.
module brbp_ram #(
  parameter int unsigned DEPTH = brbp_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [brbp_pkg::DATA_W-1:0]      wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [brbp_pkg::DATA_W-1:0]      rd_data
);
  import brbp_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/brbp_ctrl.sv -----
// Pointer control, command decode and burst read sequencer.
module brbp_ctrl #(
  parameter int unsigned DEPTH     = brbp_pkg::DEPTH_DEF,
  parameter int unsigned RESERVE   = brbp_pkg::RESERVE_DEF,
  parameter int unsigned MAX_BURST = brbp_pkg::MAX_BURST_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [brbp_pkg::OPCODE_W-1:0]    opcode,
  input  logic [brbp_pkg::AMOUNT_W-1:0]    amount,
  input  logic [brbp_pkg::OFFSET_W-1:0]    offset,
  output logic                             wr_en,
  output logic [$clog2(DEPTH)-1:0]         wr_addr,
  output logic                             rd_en,
  output logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [$clog2(DEPTH)-1:0]         used,
  output brbp_pkg::res_t                   res
);
  import brbp_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = ((PW > AMOUNT_W) ? PW : AMOUNT_W) + 1;

  state_t             state, state_next;
  logic [PW-1:0]      rp, rp_next;
  logic [PW-1:0]      wp, wp_next;
  logic [PW-1:0]      addr, addr_next;
  logic [MOVED_W-1:0] remain, remain_next;
  logic [MOVED_W-1:0] nlen, nlen_next;

  logic [CW-1:0] used_w;
  logic [CW-1:0] free_w;
  logic [CW-1:0] off_w;
  logic [CW-1:0] avail_w;
  logic [CW-1:0] cnt_w;
  logic          accept;

  function automatic logic [PW-1:0] wrap_ptr(input logic [CW-1:0] x);
    logic [CW-1:0] y;
    y = (x >= CW'(DEPTH)) ? x - CW'(DEPTH) : x;
    return y[PW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state == ST_BURST);

  // occupancy from the pointers
  always_comb begin
    if (wp >= rp) begin
      used_w = CW'(wp) - CW'(rp);
    end else begin
      used_w = CW'(DEPTH) - CW'(rp) + CW'(wp);
    end
    if (used_w + CW'(RESERVE) >= CW'(DEPTH)) begin
      free_w = '0;
    end else begin
      free_w = CW'(DEPTH) - used_w - CW'(RESERVE);
    end
  end

  assign used = used_w[PW-1:0];

  // burst length: min(amount, available, MAX_BURST)
  always_comb begin
    off_w   = (op_t'(opcode) == OP_PEEK) ? CW'(offset) : '0;
    avail_w = (off_w < used_w) ? used_w - off_w : '0;
    cnt_w   = avail_w;
    if (CW'(amount) < cnt_w) begin
      cnt_w = CW'(amount);
    end
    if (CW'(MAX_BURST) < cnt_w) begin
      cnt_w = CW'(MAX_BURST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rp     <= '0;
      wp     <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      rp     <= rp_next;
      wp     <= wp_next;
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    nlen <= nlen_next;
  end

  always_comb begin
    state_next   = state;
    rp_next      = rp;
    wp_next      = wp;
    addr_next    = addr;
    remain_next  = remain;
    nlen_next    = nlen;
    wr_en        = 1'b0;
    wr_addr      = wp;
    rd_en        = 1'b0;
    rd_addr      = addr;
    res          = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          case (op_t'(opcode))
            OP_PUSH: begin
              if (free_w != '0) begin
                res.ok  = 1'b1;
                wr_en   = 1'b1;
                wp_next = wrap_ptr(CW'(wp) + CW'(1));
              end
            end
            OP_POP, OP_PEEK: begin
              if (cnt_w != '0) begin
                // results come from the burst sequencer instead
                res.valid   = 1'b0;
                res.last    = 1'b0;
                state_next  = ST_BURST;
                addr_next   = wrap_ptr(CW'(rp) + off_w);
                remain_next = cnt_w[MOVED_W-1:0];
                nlen_next   = cnt_w[MOVED_W-1:0];
                if (op_t'(opcode) == OP_POP) begin
                  rp_next = wrap_ptr(CW'(rp) + cnt_w);
                end
              end
            end
            OP_DROP: begin
              if (CW'(amount) <= used_w) begin
                res.ok  = 1'b1;
                rp_next = wrap_ptr(CW'(rp) + CW'(amount));
              end
            end
            OP_CLEAR: begin
              res.ok  = 1'b1;
              rp_next = '0;
              wp_next = '0;
            end
            default: begin
              res.ok = 1'b0;
            end
          endcase
        end
      end
      ST_BURST: begin
        rd_en       = 1'b1;
        res.valid   = 1'b1;
        res.from_mem = 1'b1;
        res.ok      = 1'b1;
        res.moved   = nlen;
        res.last    = (remain == MOVED_W'(1));
        addr_next   = wrap_ptr(CW'(addr) + CW'(1));
        remain_next = remain - MOVED_W'(1);
        if (remain == MOVED_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BURST && remain == MOVED_W'(1)) |=> (state == ST_IDLE))
    else $error("burst did not end after its last read");

  a_burst_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BURST) |-> (remain != '0 && remain <= nlen))
    else $error("burst count out of range");

  a_reserve_kept: assert property (@(posedge clk) disable iff (rst)
    used_w + CW'(RESERVE) <= CW'(DEPTH))
    else $error("reserved gap violated");

  a_no_write_in_burst: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("store written during a burst read");
`endif

endmodule

// ----- hw/rtl/byte_ring_buffer_with_peek.sv -----
// Top level of the byte ring buffer with peek: store, controller and result register.
//
// Byte FIFO on a ring of DEPTH slots with RESERVE slots always kept empty, so it
// holds at most DEPTH - RESERVE bytes. A command (opcode, data_in, amount, offset)
// transfers at a rising edge with start high and busy low. Push, drop, clear, a
// rejected pop/peek and unknown opcodes give one result in the cycle after the
// transfer and leave busy low, so such commands can follow each other every cycle.
// A pop or peek of n bytes (n = min(amount, available, MAX_BURST), available being
// used for pop and used - offset for peek) holds busy high while the controller
// reads the store one byte per cycle through its single read port; the n results
// follow, each in the cycle after its read, one per cycle, last marking the final
// one. Each result is shown for exactly one cycle with strobe high and cannot be
// held off by the receiver. used_count and free_count always show the state after
// the whole command, so a pop already reports the bytes it removes on its first
// result. No clearing pass is needed after reset; the store contents are never
// read before being written.
module byte_ring_buffer_with_peek #(
  parameter int unsigned DEPTH     = brbp_pkg::DEPTH_DEF,
  parameter int unsigned RESERVE   = brbp_pkg::RESERVE_DEF,
  parameter int unsigned MAX_BURST = brbp_pkg::MAX_BURST_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [brbp_pkg::OPCODE_W-1:0]    opcode,
  input  logic [brbp_pkg::DATA_W-1:0]      data_in,
  input  logic [brbp_pkg::AMOUNT_W-1:0]    amount,
  input  logic [brbp_pkg::OFFSET_W-1:0]    offset,
  output logic                             strobe,
  output logic [brbp_pkg::DATA_W-1:0]      data_out,
  output logic                             last,
  output logic                             ok,
  output logic [brbp_pkg::COUNT_W-1:0]     used_count,
  output logic [brbp_pkg::COUNT_W-1:0]     free_count,
  output logic [brbp_pkg::MOVED_W-1:0]     moved
);
  import brbp_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = ((PW > COUNT_W) ? PW : COUNT_W) + 2;

  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic              rd_en;
  logic [PW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [PW-1:0]     used;
  res_t              res;
  res_t              res_q;   // lines up with the store's read latency
  logic [CW-1:0]     used_ext;
  logic [CW-1:0]     free_ext;

  brbp_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  brbp_ctrl #(
    .DEPTH     (DEPTH),
    .RESERVE   (RESERVE),
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .opcode  (opcode),
    .amount  (amount),
    .offset  (offset),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .used    (used),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_q <= '0;
    end else begin
      res_q <= res;
    end
  end

  // occupancy counts follow the live pointers; they already reflect the command
  always_comb begin
    used_ext = CW'(used);
    if (used_ext + CW'(RESERVE) >= CW'(DEPTH)) begin
      free_ext = '0;
    end else begin
      free_ext = CW'(DEPTH) - used_ext - CW'(RESERVE);
    end
  end

  assign strobe     = res_q.valid;
  assign data_out   = res_q.from_mem ? rd_data : '0;
  assign last       = res_q.last;
  assign ok         = res_q.ok;
  assign moved      = res_q.moved;
  assign used_count = used_ext[COUNT_W-1:0];
  assign free_count = free_ext[COUNT_W-1:0];

`ifndef SYNTHESIS
  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && res_q.from_mem && last) |-> !busy)
    else $error("busy still high at final burst result");

  a_burst_data_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && res_q.from_mem) |-> (ok && moved != '0))
    else $error("burst result without moved count");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !res_q.from_mem) |-> (last && moved == '0 && data_out == '0))
    else $error("single result malformed");
`endif

endmodule
